>>> rtl/core/jkvl_pkg.sv
package jkvl_pkg;

  localparam int unsigned KEY_REG_COUNT = 3;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned POS_W = 16;
  localparam int unsigned KEY_LEN_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS_LOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS_HIGH = 2'd2;

  localparam logic [2:0] KIND_STRING = 3'd0;
  localparam logic [2:0] KIND_LIST = 3'd1;
  localparam logic [2:0] KIND_OBJECT = 3'd2;
  localparam logic [2:0] KIND_TRUE = 3'd3;
  localparam logic [2:0] KIND_FALSE = 3'd4;
  localparam logic [2:0] KIND_NULL = 3'd5;
  localparam logic [2:0] KIND_NUMBER = 3'd6;
  localparam logic [2:0] KIND_NONE = 3'd7;

  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_NO_KEY = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DEPTH = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;

  typedef enum logic [7:0] {
    PH_KEY    = 8'b0000_0001,
    PH_COLON  = 8'b0000_0010,
    PH_BLANK  = 8'b0000_0100,
    PH_STRING = 8'b0000_1000,
    PH_NEST   = 8'b0001_0000,
    PH_LIT    = 8'b0010_0000,
    PH_NUM    = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] value_start;
    logic [POS_W-1:0] value_stop;
    logic [2:0] value_kind;
    logic [2:0] status;
  } result_t;

  function automatic logic [2:0] lit_len(input logic [2:0] kind);
    return (kind == KIND_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [2:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == KIND_TRUE) begin
      unique case (idx)
        3'd0: ch = 8'h74;
        3'd1: ch = 8'h72;
        3'd2: ch = 8'h75;
        3'd3: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else if (kind == KIND_FALSE) begin
      unique case (idx)
        3'd0: ch = 8'h66;
        3'd1: ch = 8'h61;
        3'd2: ch = 8'h6c;
        3'd3: ch = 8'h73;
        3'd4: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0: ch = 8'h6e;
        3'd1: ch = 8'h75;
        3'd2: ch = 8'h6c;
        3'd3: ch = 8'h6c;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c == CH_DOT) || ((c >= CH_ZERO) && (c <= CH_NINE));
  endfunction

endpackage

>>> rtl/core/json_key_value_locator_unit.sv
// Locates the value of one quoted key in a JSON text streamed one byte per request
// (tlast marks the final byte). Throughput is one byte per clock unless stalled: every
// byte goes through a single state update. A spare result register sits behind the
// output register, so s_tready drops only while two finished results wait unread,
// never while just one does. A result appears on m_tdata the cycle after the byte that
// decides it (or the final byte) when the output is free; exactly one result per text.
// Offsets saturate at MAX_TEXT_BYTES, nesting depth is limited to MAX_DEPTH, and the
// key registers may be rewritten only between texts.
module json_key_value_locator_unit #(
  parameter int unsigned KEY_MAX_BYTES = 16,
  parameter int unsigned MAX_TEXT_BYTES = 65535,
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [jkvl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jkvl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // text_byte[7:0]
  input  logic s_tlast,         // last_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [39:0] m_tdata   // value_start[15:0], value_stop[31:16],
                                // value_kind[34:32], status[37:35], zero[39:38]
);

  localparam int unsigned WIN = KEY_MAX_BYTES + 2;
  localparam int unsigned CNT_W = $clog2(WIN + 1);
  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned POS_W = jkvl_pkg::POS_W;
  localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WIN);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX_C = DEPTH_W'(MAX_DEPTH);
  localparam logic [POS_W-1:0] POS_MAX_C = POS_W'(MAX_TEXT_BYTES);
  localparam logic [jkvl_pkg::KEY_LEN_W-1:0] KEY_MAX_C = jkvl_pkg::KEY_LEN_W'(KEY_MAX_BYTES);

  logic [jkvl_pkg::KEY_LEN_W-1:0] key_length;
  logic [63:0] key_chars_low;
  logic [63:0] key_chars_high;

  jkvl_pkg::phase_t phase, phase_next;
  logic [CNT_W-1:0] match_count, match_count_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] found_start, found_start_next;
  logic [DEPTH_W-1:0] nesting_depth, nesting_depth_next;
  logic [2:0] found_kind, found_kind_next;
  logic [2:0] literal_index, literal_index_next;
  logic in_str, in_str_next;
  logic esc, esc_next;
  logic [7:0] window [WIN];
  logic [7:0] window_next [WIN];

  jkvl_pkg::result_t res;
  jkvl_pkg::result_t out_res;
  jkvl_pkg::result_t skid_res;
  logic skid_valid;
  logic res_valid;
  logic in_acc;
  logic out_load;
  logic out_free;

  logic [7:0] key_bytes [16];
  logic [jkvl_pkg::KEY_LEN_W-1:0] kl_eff;
  logic key_hit;
  logic [7:0] c;
  logic [POS_W-1:0] cur, nxt;
  logic [7:0] op_ch, cl_ch;
  logic [3:0] lit_k1;

  assign c = s_tdata;
  assign cur = byte_position;
  assign nxt = (cur >= POS_MAX_C) ? POS_MAX_C : cur + POS_W'(1);
  assign kl_eff = (key_length > KEY_MAX_C) ? KEY_MAX_C : key_length;
  assign s_tready = !skid_valid;
  assign in_acc = s_tvalid && s_tready;
  assign out_load = in_acc && res_valid;
  assign out_free = !m_tvalid || m_tready;
  assign op_ch = (found_kind == jkvl_pkg::KIND_LIST) ? jkvl_pkg::CH_LBRACK
                                                     : jkvl_pkg::CH_LBRACE;
  assign cl_ch = (found_kind == jkvl_pkg::KIND_LIST) ? jkvl_pkg::CH_RBRACK
                                                     : jkvl_pkg::CH_RBRACE;
  assign lit_k1 = {1'b0, literal_index} + 4'd1;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_bytes[i] = key_chars_low[8*i +: 8];
      key_bytes[i+8] = key_chars_high[8*i +: 8];
    end
  end

  // shifted key window with the incoming byte in slot 0
  always_comb begin
    window_next[0] = c;
    for (int j = 1; j < WIN; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // one match term per possible key length, selected by the programmed length
  always_comb begin
    logic m;
    logic [CNT_W:0] cnt_after;
    key_hit = 1'b0;
    cnt_after = (match_count < WIN_C) ? {1'b0, match_count} + (CNT_W+1)'(1)
                                      : {1'b0, match_count};
    for (int k = 0; k <= KEY_MAX_BYTES; k++) begin
      m = (window_next[0] == jkvl_pkg::CH_QUOTE) && (window_next[k+1] == jkvl_pkg::CH_QUOTE);
      for (int j = 1; j <= k; j++) begin
        m = m && (window_next[j] == key_bytes[k-j]);
      end
      if ((kl_eff == jkvl_pkg::KEY_LEN_W'(k)) && m &&
          (cnt_after >= (CNT_W+1)'(k + 2))) begin
        key_hit = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    match_count_next = match_count;
    byte_position_next = nxt;
    found_start_next = found_start;
    nesting_depth_next = nesting_depth;
    found_kind_next = found_kind;
    literal_index_next = literal_index;
    in_str_next = in_str;
    esc_next = esc;
    res_valid = 1'b0;
    res = '{value_start: '0, value_stop: '0, value_kind: jkvl_pkg::KIND_NONE,
            status: jkvl_pkg::ST_FOUND};

    unique case (phase)
      jkvl_pkg::PH_KEY: begin
        if (match_count < WIN_C) begin
          match_count_next = match_count + CNT_W'(1);
        end
        if (key_hit) begin
          phase_next = jkvl_pkg::PH_COLON;
        end
      end
      jkvl_pkg::PH_COLON: begin
        phase_next = jkvl_pkg::PH_BLANK;
      end
      jkvl_pkg::PH_BLANK: begin
        if (c != jkvl_pkg::CH_SPACE) begin
          found_start_next = cur;
          in_str_next = 1'b0;
          esc_next = 1'b0;
          if (c == jkvl_pkg::CH_QUOTE) begin
            found_kind_next = jkvl_pkg::KIND_STRING;
            found_start_next = nxt;
            phase_next = jkvl_pkg::PH_STRING;
          end else if (c == jkvl_pkg::CH_LBRACK || c == jkvl_pkg::CH_LBRACE) begin
            found_kind_next = (c == jkvl_pkg::CH_LBRACK) ? jkvl_pkg::KIND_LIST
                                                         : jkvl_pkg::KIND_OBJECT;
            nesting_depth_next = DEPTH_W'(1);
            phase_next = jkvl_pkg::PH_NEST;
          end else if (c == jkvl_pkg::CH_T || c == jkvl_pkg::CH_F || c == jkvl_pkg::CH_N) begin
            found_kind_next = (c == jkvl_pkg::CH_T) ? jkvl_pkg::KIND_TRUE :
                              (c == jkvl_pkg::CH_F) ? jkvl_pkg::KIND_FALSE :
                                                      jkvl_pkg::KIND_NULL;
            literal_index_next = 3'd1;
            phase_next = jkvl_pkg::PH_LIT;
          end else if (c == jkvl_pkg::CH_MINUS || jkvl_pkg::is_num(c)) begin
            found_kind_next = jkvl_pkg::KIND_NUMBER;
            phase_next = jkvl_pkg::PH_NUM;
          end else begin
            res_valid = 1'b1;
            res = '{value_start: cur, value_stop: cur, value_kind: jkvl_pkg::KIND_NONE,
                    status: jkvl_pkg::ST_INVALID};
          end
        end
      end
      jkvl_pkg::PH_STRING: begin
        if (esc) begin
          esc_next = 1'b0;
        end else if (c == jkvl_pkg::CH_BSLASH) begin
          esc_next = 1'b1;
        end else if (c == jkvl_pkg::CH_QUOTE) begin
          res_valid = 1'b1;
          res = '{value_start: found_start, value_stop: cur,
                  value_kind: jkvl_pkg::KIND_STRING, status: jkvl_pkg::ST_FOUND};
        end
      end
      jkvl_pkg::PH_NEST: begin
        if (in_str) begin
          if (esc) begin
            esc_next = 1'b0;
          end else if (c == jkvl_pkg::CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (c == jkvl_pkg::CH_QUOTE) begin
            in_str_next = 1'b0;
          end
        end else if (c == jkvl_pkg::CH_QUOTE) begin
          in_str_next = 1'b1;
        end else if (c == op_ch) begin
          if (nesting_depth >= DEPTH_MAX_C) begin
            res_valid = 1'b1;
            res = '{value_start: found_start, value_stop: nxt,
                    value_kind: found_kind, status: jkvl_pkg::ST_DEPTH};
          end else begin
            nesting_depth_next = nesting_depth + DEPTH_W'(1);
          end
        end else if (c == cl_ch) begin
          nesting_depth_next = nesting_depth - DEPTH_W'(1);
          if (nesting_depth == DEPTH_W'(1)) begin
            res_valid = 1'b1;
            res = '{value_start: found_start, value_stop: nxt,
                    value_kind: found_kind, status: jkvl_pkg::ST_FOUND};
          end
        end
      end
      jkvl_pkg::PH_LIT: begin
        if (literal_index >= jkvl_pkg::lit_len(found_kind) ||
            c != jkvl_pkg::lit_char(found_kind, literal_index)) begin
          res_valid = 1'b1;
          res = '{value_start: found_start, value_stop: found_start,
                  value_kind: jkvl_pkg::KIND_NONE, status: jkvl_pkg::ST_INVALID};
        end else begin
          literal_index_next = lit_k1[2:0];
          if (lit_k1 >= {1'b0, jkvl_pkg::lit_len(found_kind)}) begin
            res_valid = 1'b1;
            res = '{value_start: found_start, value_stop: nxt,
                    value_kind: found_kind, status: jkvl_pkg::ST_FOUND};
          end
        end
      end
      jkvl_pkg::PH_NUM: begin
        if (!jkvl_pkg::is_num(c)) begin
          res_valid = 1'b1;
          res = '{value_start: found_start, value_stop: cur,
                  value_kind: jkvl_pkg::KIND_NUMBER, status: jkvl_pkg::ST_FOUND};
        end
      end
      jkvl_pkg::PH_DONE: begin
      end
      default: begin
        phase_next = jkvl_pkg::PH_DONE;
      end
    endcase

    if (res_valid) begin
      phase_next = jkvl_pkg::PH_DONE;
    end

    if (s_tlast) begin
      if (!res_valid) begin
        priority case (phase_next)
          jkvl_pkg::PH_KEY: begin
            res_valid = 1'b1;
            res = '{value_start: '0, value_stop: '0, value_kind: jkvl_pkg::KIND_NONE,
                    status: jkvl_pkg::ST_NO_KEY};
          end
          jkvl_pkg::PH_COLON, jkvl_pkg::PH_BLANK: begin
            res_valid = 1'b1;
            res = '{value_start: nxt, value_stop: nxt, value_kind: jkvl_pkg::KIND_NONE,
                    status: jkvl_pkg::ST_TRUNCATED};
          end
          jkvl_pkg::PH_NUM: begin
            res_valid = 1'b1;
            res = '{value_start: found_start_next, value_stop: nxt,
                    value_kind: jkvl_pkg::KIND_NUMBER, status: jkvl_pkg::ST_FOUND};
          end
          jkvl_pkg::PH_DONE: begin
          end
          default: begin
            res_valid = 1'b1;
            res = '{value_start: found_start_next, value_stop: nxt,
                    value_kind: found_kind_next, status: jkvl_pkg::ST_TRUNCATED};
          end
        endcase
      end
      phase_next = jkvl_pkg::PH_KEY;
      match_count_next = '0;
      byte_position_next = '0;
      found_start_next = '0;
      nesting_depth_next = '0;
      found_kind_next = jkvl_pkg::KIND_NONE;
      literal_index_next = '0;
      in_str_next = 1'b0;
      esc_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= jkvl_pkg::KEY_LEN_W'(1);
      key_chars_low <= '0;
      key_chars_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        jkvl_pkg::REG_KEY_LENGTH: key_length <= cfg_data[jkvl_pkg::KEY_LEN_W-1:0];
        jkvl_pkg::REG_KEY_CHARS_LOW: key_chars_low <= cfg_data;
        jkvl_pkg::REG_KEY_CHARS_HIGH: key_chars_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jkvl_pkg::PH_KEY;
      match_count <= '0;
      byte_position <= '0;
      found_start <= '0;
      nesting_depth <= '0;
      found_kind <= jkvl_pkg::KIND_NONE;
      literal_index <= '0;
      in_str <= 1'b0;
      esc <= 1'b0;
    end else if (in_acc) begin
      phase <= phase_next;
      match_count <= match_count_next;
      byte_position <= byte_position_next;
      found_start <= found_start_next;
      nesting_depth <= nesting_depth_next;
      found_kind <= found_kind_next;
      literal_index <= literal_index_next;
      in_str <= in_str_next;
      esc <= esc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && phase == jkvl_pkg::PH_KEY) begin
      for (int j = 0; j < WIN; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

  // a new result parks in skid_res while the output register is still unread
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_load) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && m_tready) begin
      out_res <= skid_res;
    end else if (out_load && out_free) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && !out_free) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.status, out_res.value_kind,
                    out_res.value_stop, out_res.value_start};

`ifndef SYNTHESIS
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> phase == jkvl_pkg::PH_KEY && byte_position == '0)
    else $error("block did not rearm after final byte");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && phase == jkvl_pkg::PH_DONE && !s_tlast |-> !res_valid)
    else $error("second result within one text");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_load |-> res.value_start <= res.value_stop)
    else $error("value start beyond value stop");

  a_no_key_last: assert property (@(posedge clk) disable iff (rst)
    out_load && res.status == jkvl_pkg::ST_NO_KEY |-> s_tlast)
    else $error("key-not-found result before final byte");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    nesting_depth <= DEPTH_MAX_C)
    else $error("nesting depth above limit");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("held result without output result");
`endif

endmodule

>>> test/tb_json_key_value_locator_unit.sv
`timescale 1ns / 1ps

module tb_json_key_value_locator_unit;

  localparam int unsigned POS_LIMIT = 65535;
  localparam int unsigned DEPTH_LIMIT = 255;
  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned WIN_LEN = KEY_BYTES + 2;
  localparam logic [jkvl_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [jkvl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [jkvl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  json_key_value_locator_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  class kv_span_scoreboard;
    logic [4:0] key_len;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    jkvl_pkg::phase_t ph;
    int unsigned seen;
    int unsigned pos;
    int unsigned vstart;
    int unsigned depth;
    int unsigned lit_idx;
    logic [2:0] kind;
    bit in_str;
    bit esc;
    logic [7:0] win [WIN_LEN];
    jkvl_pkg::result_t span_q [$];
    int errors;

    function new();
      key_len = 5'd1;
      key_lo = '0;
      key_hi = '0;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      ph = jkvl_pkg::PH_KEY;
      seen = 0;
      pos = 0;
      vstart = 0;
      depth = 0;
      kind = jkvl_pkg::KIND_NONE;
      lit_idx = 0;
      in_str = 1'b0;
      esc = 1'b0;
      foreach (win[i]) win[i] = 8'h00;
    endfunction

    function void set_key(logic [4:0] len, logic [63:0] lo, logic [63:0] hi);
      key_len = len;
      key_lo = lo;
      key_hi = hi;
    endfunction

    function int unsigned bump(int unsigned p);
      return (p >= POS_LIMIT) ? POS_LIMIT : p + 1;
    endfunction

    function logic [7:0] key_char(int unsigned j);
      logic [63:0] w;
      w = (j < 8) ? key_lo : key_hi;
      return w[(j % 8) * 8 +: 8];
    endfunction

    function bit key_seen();
      int unsigned plen;
      logic [7:0] want;
      plen = ((key_len > KEY_BYTES) ? KEY_BYTES : key_len) + 2;
      if (seen < plen) return 1'b0;
      for (int i = 0; i < plen; i++) begin
        want = (i == 0 || i == plen - 1) ? jkvl_pkg::CH_QUOTE : key_char(i - 1);
        if (win[plen - 1 - i] != want) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit numeric(logic [7:0] c);
      return c == jkvl_pkg::CH_DOT || (c >= jkvl_pkg::CH_ZERO && c <= jkvl_pkg::CH_NINE);
    endfunction

    function string literal_of(logic [2:0] k);
      return (k == jkvl_pkg::KIND_TRUE) ? "true" :
             ((k == jkvl_pkg::KIND_FALSE) ? "false" : "null");
    endfunction

    function void decide(int unsigned a, int unsigned b, logic [2:0] k, logic [2:0] st);
      jkvl_pkg::result_t r;
      r.value_start = a[15:0];
      r.value_stop = b[15:0];
      r.value_kind = k;
      r.status = st;
      span_q.push_back(r);
      ph = jkvl_pkg::PH_DONE;
    endfunction

    function void note_byte(logic [7:0] c, bit last);
      int unsigned cur;
      int unsigned nxt;
      int unsigned k;
      string lit;
      logic [7:0] op;
      logic [7:0] cl;
      cur = pos;
      nxt = bump(cur);
      case (ph)
        jkvl_pkg::PH_KEY: begin
          for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i - 1];
          win[0] = c;
          if (seen < WIN_LEN) seen++;
          if (key_seen()) ph = jkvl_pkg::PH_COLON;
        end
        jkvl_pkg::PH_COLON: ph = jkvl_pkg::PH_BLANK;
        jkvl_pkg::PH_BLANK: begin
          if (c != jkvl_pkg::CH_SPACE) begin
            vstart = cur;
            in_str = 1'b0;
            esc = 1'b0;
            if (c == jkvl_pkg::CH_QUOTE) begin
              kind = jkvl_pkg::KIND_STRING;
              vstart = nxt;
              ph = jkvl_pkg::PH_STRING;
            end else if (c == jkvl_pkg::CH_LBRACK || c == jkvl_pkg::CH_LBRACE) begin
              kind = (c == jkvl_pkg::CH_LBRACK) ? jkvl_pkg::KIND_LIST : jkvl_pkg::KIND_OBJECT;
              depth = 1;
              ph = jkvl_pkg::PH_NEST;
            end else if (c == jkvl_pkg::CH_T || c == jkvl_pkg::CH_F || c == jkvl_pkg::CH_N) begin
              kind = (c == jkvl_pkg::CH_T) ? jkvl_pkg::KIND_TRUE :
                     ((c == jkvl_pkg::CH_F) ? jkvl_pkg::KIND_FALSE : jkvl_pkg::KIND_NULL);
              lit_idx = 1;
              ph = jkvl_pkg::PH_LIT;
            end else if (c == jkvl_pkg::CH_MINUS || numeric(c)) begin
              kind = jkvl_pkg::KIND_NUMBER;
              ph = jkvl_pkg::PH_NUM;
            end else begin
              decide(cur, cur, jkvl_pkg::KIND_NONE, jkvl_pkg::ST_INVALID);
            end
          end
        end
        jkvl_pkg::PH_STRING: begin
          if (esc) esc = 1'b0;
          else if (c == jkvl_pkg::CH_BSLASH) esc = 1'b1;
          else if (c == jkvl_pkg::CH_QUOTE)
            decide(vstart, cur, jkvl_pkg::KIND_STRING, jkvl_pkg::ST_FOUND);
        end
        jkvl_pkg::PH_NEST: begin
          op = (kind == jkvl_pkg::KIND_LIST) ? jkvl_pkg::CH_LBRACK : jkvl_pkg::CH_LBRACE;
          cl = (kind == jkvl_pkg::KIND_LIST) ? jkvl_pkg::CH_RBRACK : jkvl_pkg::CH_RBRACE;
          if (in_str) begin
            if (esc) esc = 1'b0;
            else if (c == jkvl_pkg::CH_BSLASH) esc = 1'b1;
            else if (c == jkvl_pkg::CH_QUOTE) in_str = 1'b0;
          end else if (c == jkvl_pkg::CH_QUOTE) begin
            in_str = 1'b1;
          end else if (c == op) begin
            if (depth >= DEPTH_LIMIT) decide(vstart, nxt, kind, jkvl_pkg::ST_DEPTH);
            else depth++;
          end else if (c == cl) begin
            depth--;
            if (depth == 0) decide(vstart, nxt, kind, jkvl_pkg::ST_FOUND);
          end
        end
        jkvl_pkg::PH_LIT: begin
          lit = literal_of(kind);
          k = lit_idx & 7;
          if (k >= lit.len() || c != lit[k]) begin
            decide(vstart, vstart, jkvl_pkg::KIND_NONE, jkvl_pkg::ST_INVALID);
          end else begin
            lit_idx = k + 1;
            if (lit_idx >= lit.len()) decide(vstart, nxt, kind, jkvl_pkg::ST_FOUND);
          end
        end
        jkvl_pkg::PH_NUM: begin
          if (!numeric(c)) decide(vstart, cur, jkvl_pkg::KIND_NUMBER, jkvl_pkg::ST_FOUND);
        end
        default: ;
      endcase
      pos = nxt;
      if (last) begin
        case (ph)
          jkvl_pkg::PH_KEY: decide(0, 0, jkvl_pkg::KIND_NONE, jkvl_pkg::ST_NO_KEY);
          jkvl_pkg::PH_COLON, jkvl_pkg::PH_BLANK:
            decide(nxt, nxt, jkvl_pkg::KIND_NONE, jkvl_pkg::ST_TRUNCATED);
          jkvl_pkg::PH_NUM: decide(vstart, nxt, jkvl_pkg::KIND_NUMBER, jkvl_pkg::ST_FOUND);
          jkvl_pkg::PH_DONE: ;
          default: decide(vstart, nxt, kind, jkvl_pkg::ST_TRUNCATED);
        endcase
        rearm();
      end
    endfunction

    function bit pending();
      return span_q.size() != 0;
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        if (errors <= 50)
          $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [39:0] d);
      jkvl_pkg::result_t e;
      if (span_q.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: result expected none actual start %0d stop %0d kind %0d status %0d",
                   $time, d[15:0], d[31:16], d[34:32], d[37:35]);
        return;
      end
      e = span_q.pop_front();
      compare("value_start", e.value_start, d[15:0]);
      compare("value_stop", e.value_stop, d[31:16]);
      compare("value_kind", e.value_kind, d[34:32]);
      compare("status", e.status, d[37:35]);
    endfunction
  endclass

  kv_span_scoreboard sb;
  logic [7:0] text_q [$];
  logic [7:0] key_bytes [KEY_BYTES];
  logic [63:0] key_len_word;
  int unsigned valid_idle_pct;
  int unsigned ready_idle_pct;

  string directed [] = '{
    "{\"id\": \"ab\\\"c\"}",
    "{\"id\":[1,\"]\",[2]],\"z\":0}",
    "{\"id\":{\"a\":{\"b\":\"}\\\"{\"}}}",
    "\"id\":true",
    "\"id\":false,",
    "\"id\":null}",
    "\"id\":-12.5}",
    "\"id\": .5,",
    "\"id\":42",
    "\"id\":tru",
    "\"id\":trux1",
    "\"id\":nul7",
    "\"id\":@x",
    "{\"x\":1}",
    "\"id\"",
    "\"id\":",
    "\"id\":   ",
    "\"id\":\"abc",
    "\"id\"=  [1,{2}]",
    "\"id\":1 xyz\"id\":2",
    "x",
    "\"id\":[\"a\\\\\",[]]",
    "\"id\":{\"k\":[1,2]"
  };

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= ready_idle_pct);
  end

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] noise_byte();
    string pool;
    pool = "{}[],:\" ab\\";
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic void push_key(bit spoil);
    int unsigned n;
    logic [7:0] b;
    n = (key_len_word[4:0] > KEY_BYTES) ? KEY_BYTES : key_len_word[4:0];
    text_q.push_back(jkvl_pkg::CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      b = key_bytes[i];
      if (spoil && i == n - 1) b = b ^ (8'd1 << $urandom_range(7));
      text_q.push_back(b);
    end
    if (spoil && n == 0) text_q.push_back(8'h78);
    text_q.push_back(jkvl_pkg::CH_QUOTE);
  endfunction

  function automatic void push_text_string();
    logic [7:0] b;
    text_q.push_back(jkvl_pkg::CH_QUOTE);
    repeat ($urandom_range(8)) begin
      b = ($urandom_range(3) == 0) ? noise_byte() : 8'($urandom_range(255));
      if (b == jkvl_pkg::CH_QUOTE || b == jkvl_pkg::CH_BSLASH || $urandom_range(9) == 0)
        text_q.push_back(jkvl_pkg::CH_BSLASH);
      text_q.push_back(b);
    end
    text_q.push_back(jkvl_pkg::CH_QUOTE);
  endfunction

  function automatic void push_number();
    case ($urandom_range(2))
      0: text_q.push_back(jkvl_pkg::CH_MINUS);
      1: text_q.push_back(jkvl_pkg::CH_DOT);
      default: text_q.push_back(jkvl_pkg::CH_ZERO + 8'($urandom_range(9)));
    endcase
    repeat ($urandom_range(6))
      text_q.push_back(($urandom_range(5) == 0) ? jkvl_pkg::CH_DOT
                                                : jkvl_pkg::CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void push_literal(string s, bit spoil);
    int unsigned at;
    logic [7:0] b;
    at = $urandom_range(1, s.len() - 1);
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (spoil && i == at) b = b ^ 8'($urandom_range(1, 255));
      text_q.push_back(b);
    end
  endfunction

  function automatic void push_nest(logic [7:0] op, logic [7:0] cl, int unsigned lvl);
    int unsigned n;
    text_q.push_back(op);
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) text_q.push_back(CH_COMMA);
      case ($urandom_range(4))
        0: push_number();
        1: push_text_string();
        2: begin
          if (lvl < 3) push_nest(op, cl, lvl + 1);
          else push_number();
        end
        3: push_str((op == jkvl_pkg::CH_LBRACK) ? "{x}" : "[x]");
        default: push_literal("null", 1'b0);
      endcase
    end
    text_q.push_back(cl);
  endfunction

  function automatic bit starts_value(logic [7:0] b);
    return b == jkvl_pkg::CH_SPACE || b == jkvl_pkg::CH_QUOTE ||
           b == jkvl_pkg::CH_LBRACK || b == jkvl_pkg::CH_LBRACE ||
           b == jkvl_pkg::CH_T || b == jkvl_pkg::CH_F || b == jkvl_pkg::CH_N ||
           b == jkvl_pkg::CH_MINUS || b == jkvl_pkg::CH_DOT ||
           (b >= jkvl_pkg::CH_ZERO && b <= jkvl_pkg::CH_NINE);
  endfunction

  function automatic void push_unknown();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (starts_value(b)) b = 8'($urandom_range(255));
    text_q.push_back(b);
  endfunction

  // mostly well-formed key/value texts, some noise, some cut short
  function automatic void gen_text();
    int unsigned r;
    int unsigned vpos;
    text_q.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(5)) text_q.push_back(noise_byte());
    r = $urandom_range(99);
    if (r < 85) begin
      push_key(1'b0);
    end else if (r < 93) begin
      push_key(1'b1);
      if ($urandom_range(1) == 1) push_key(1'b0);
    end
    text_q.push_back(($urandom_range(99) < 88) ? CH_COLON : 8'($urandom_range(255)));
    repeat ($urandom_range(3)) text_q.push_back(jkvl_pkg::CH_SPACE);
    vpos = text_q.size();
    case ($urandom_range(7))
      0: push_text_string();
      1: push_nest(jkvl_pkg::CH_LBRACK, jkvl_pkg::CH_RBRACK, 0);
      2: push_nest(jkvl_pkg::CH_LBRACE, jkvl_pkg::CH_RBRACE, 0);
      3: push_literal("true", $urandom_range(99) < 20);
      4: push_literal("false", $urandom_range(99) < 20);
      5: push_literal("null", $urandom_range(99) < 20);
      6: push_number();
      default: push_unknown();
    endcase
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, text_q.size() - vpos)) void'(text_q.pop_back());
    end else begin
      repeat ($urandom_range(4)) text_q.push_back(noise_byte());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < valid_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_key();
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[i * 8 +: 8] = key_bytes[i];
      hi[i * 8 +: 8] = key_bytes[i + 8];
    end
    cfg_write <= 1'b1;
    cfg_index <= jkvl_pkg::REG_KEY_LENGTH;
    cfg_data <= key_len_word;
    @(posedge clk);
    cfg_index <= jkvl_pkg::REG_KEY_CHARS_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= jkvl_pkg::REG_KEY_CHARS_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_key(key_len_word[4:0], lo, hi);
  endtask

  task automatic use_key(string s, logic [63:0] lw);
    foreach (key_bytes[i]) key_bytes[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    key_len_word = lw;
    settle();
    program_key();
  endtask

  task automatic random_key();
    int unsigned r;
    logic [4:0] len;
    r = $urandom_range(99);
    if (r < 6) len = 5'd0;
    else if (r < 14) len = 5'($urandom_range(17, 31));
    else if (r < 24) len = 5'd16;
    else len = 5'($urandom_range(1, 16));
    key_len_word = ($urandom_range(2) == 0) ? {$urandom, $urandom} : 64'd0;
    key_len_word[4:0] = len;
    r = $urandom_range(3);
    foreach (key_bytes[i])
      key_bytes[i] = (r == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h7a, 8'h61));
    settle();
    program_key();
  endtask

  task automatic run_random(int unsigned byte_goal, int unsigned text_goal);
    int unsigned nbytes;
    int unsigned ntexts;
    nbytes = 0;
    ntexts = 0;
    while (nbytes < byte_goal || ntexts < text_goal) begin
      if (ntexts % 6 == 0) random_key();
      gen_text();
      nbytes += text_q.size();
      send_text();
      ntexts++;
    end
  endtask

  initial begin
    sb = new();
    valid_idle_pct = 31;
    ready_idle_pct = 45;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    use_key("id", 64'd2);
    foreach (directed[i]) begin
      text_q.delete();
      push_str(directed[i]);
      send_text();
    end

    // one level deeper than the limit
    text_q.delete();
    push_str("\"id\":");
    repeat (DEPTH_LIMIT + 1) text_q.push_back(jkvl_pkg::CH_LBRACK);
    text_q.push_back(jkvl_pkg::CH_RBRACK);
    send_text();

    // empty key
    use_key("", 64'd0);
    text_q.delete();
    push_str("{\"\":5}");
    send_text();
    text_q.delete();
    push_str("\"\"\"\"x");
    send_text();

    settle();
    foreach (key_bytes[i]) key_bytes[i] = 8'hff;
    key_len_word = 64'd16;
    program_key();
    text_q.delete();
    push_key(1'b0);
    push_str(":null");
    send_text();

    // length above the key size acts as full size
    settle();
    foreach (key_bytes[i]) key_bytes[i] = 8'h00;
    key_len_word = {$urandom, $urandom};
    key_len_word[4:0] = 5'd31;
    program_key();
    text_q.delete();
    push_key(1'b0);
    push_str(":{}");
    send_text();
    text_q.delete();
    push_key(1'b1);
    push_str(":1");
    send_text();

    run_random(160, 8);

    settle();
    valid_idle_pct = 45;
    ready_idle_pct = 31;
    run_random(160, 8);

    settle();
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    run_random(160, 8);

    settle();
    if (sb.errors == 0 && !sb.pending()) begin
      $display("tb_json_key_value_locator_unit: PASS");
    end else begin
      $display("tb_json_key_value_locator_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_json_key_value_locator_unit: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/jkvl_pkg.sv
rtl/core/json_key_value_locator_unit.sv
test/tb_json_key_value_locator_unit.sv
